// ----- src/dabd_pkg.sv -----
// Shared types, constants and calendar functions of the business-day date walker.
`default_nettype none
package dabd_pkg;

  localparam int YEAR_W = 14;
  localparam int MONTH_W = 4;
  localparam int DAY_W = 5;
  localparam int DAYS_WIDTH = 16;
  localparam int VAC_W = 16;
  localparam int WDAY_W = 3;

  localparam int IN_TDATA_W = 40;
  localparam int OUT_TDATA_W = 24;

  localparam logic [YEAR_W-1:0] YEAR_MIN = 14'd1583;
  localparam logic [YEAR_W-1:0] YEAR_MAX = 14'd9999;
  localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;
  localparam logic [WDAY_W-1:0] SATURDAY = 3'd5;
  localparam logic [WDAY_W-1:0] SUNDAY = 3'd6;

  // floor(y / 100) == (y * RECIP_100) >> 19 for every y below 10000
  localparam logic [12:0] RECIP_100 = 13'd5243;
  // floor(h / 7) == (h * RECIP_7) >> 16 for every h below 1024
  localparam logic [13:0] RECIP_7 = 14'd9363;

  localparam logic [DAY_W-1:0] MONTH_LEN [12] = '{
    5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
    5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
  };

  typedef struct packed {
    logic load;
    logic div;
    logic rem;
    logic zel;
    logic mod;
    logic wday;
    logic step;
    logic dec;
    logic set_err;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic bad;
    logic weekend;
    logic rem_zero;
    logic at_end;
  } stat_t;

  typedef struct packed {
    logic [YEAR_W-1:0] year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0] day;
    logic err;
  } res_t;

  function automatic logic [DAY_W-1:0] days_in(input logic [MONTH_W-1:0] m,
                                               input logic leap);
    logic [DAY_W-1:0] len;
    len = '0;
    if (m == 4'd2) begin
      len = leap ? 5'd29 : 5'd28;
    end else if (m != 4'd0 && m <= MONTH_DEC) begin
      len = MONTH_LEN[4'(m - 4'd1)];
    end
    return len;
  endfunction

  // floor(13 * (m + 1) / 5) for the shifted month 3..14
  function automatic logic [5:0] zel_month(input logic [MONTH_W-1:0] m);
    logic [5:0] t;
    case (m)
      4'd3:    t = 6'd10;
      4'd4:    t = 6'd13;
      4'd5:    t = 6'd15;
      4'd6:    t = 6'd18;
      4'd7:    t = 6'd20;
      4'd8:    t = 6'd23;
      4'd9:    t = 6'd26;
      4'd10:   t = 6'd28;
      4'd11:   t = 6'd31;
      4'd12:   t = 6'd33;
      4'd13:   t = 6'd36;
      4'd14:   t = 6'd39;
      default: t = 6'd0;
    endcase
    return t;
  endfunction

endpackage
`default_nettype wire

// ----- src/date_after_business_days.sv -----
// Top level of the business-day date walker: stream ports and result register.
`default_nettype none
// Takes a Gregorian start date and a number of business days off and returns
// the first business day after the vacation (Monday to Friday count as
// business days). One word is worked at a time: after the word is taken, the
// setup steps (divide, remainder, Zeller sum, modulo, weekday) check the date
// and find its weekday by Zeller's congruence using reciprocal multiplies,
// then the walker steps one calendar day per cycle through a leading weekend
// skip, the business-day count-down and a trailing weekend skip. Each pass
// ends without a step once its condition is met, and the done state hands the
// result on once the output register is free; only then is the next word
// taken, as the single day-stepping datapath serves one request at a time. An
// invalid start date (year outside 1583..9999, bad month or day) is flagged
// in the modulo step, which skips the walk and goes straight to the hand-off.
// An invalid start date or a walk that would pass 9999-12-31 raises
// date_error and echoes the start date. The result waits in an output
// register, so the next word is taken while it is held.
module date_after_business_days (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              s_tvalid,
  output logic                                   s_tready,
  // start_year[13:0], start_month[17:14], start_day[22:18],
  // vacation_days[38:23], zero[39]
  input  wire logic [dabd_pkg::IN_TDATA_W-1:0]   s_tdata,
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  // return_year[13:0], return_month[17:14], return_day[22:18], zero[23]
  output logic [dabd_pkg::OUT_TDATA_W-1:0]       m_tdata,
  // date_error[0]
  output logic                                   m_tuser
);

  dabd_pkg::cmd_t cmd;
  dabd_pkg::stat_t st;
  dabd_pkg::res_t res;
  logic out_free;

  // the result register can take a new word when empty or being drained
  assign out_free = !m_tvalid || m_tready;

  dabd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .out_free (out_free),
    .st       (st),
    .cmd      (cmd)
  );

  dabd_dp u_dp (
    .clk      (clk),
    .cmd      (cmd),
    .in_year  (s_tdata[13:0]),
    .in_month (s_tdata[17:14]),
    .in_day   (s_tdata[22:18]),
    .in_vac   (s_tdata[38:23]),
    .st       (st),
    .res      (res)
  );

  // output register: load on finish, drop valid once the word is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.finish) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      m_tdata <= {1'b0, res.day, res.month, res.year};
      m_tuser <= res.err;
    end
  end

  // a finished result never overwrites a word still waiting downstream
  assert property (@(posedge clk) disable iff (rst) cmd.finish |-> out_free)
    else $error("result loaded over a waiting word");

  // once a word is taken the block is busy with it
  assert property (@(posedge clk) disable iff (rst) (s_tvalid && s_tready) |=> !s_tready)
    else $error("input taken again while a request is in flight");

  // output valid only rises after a finished walk
  assert property (@(posedge clk) disable iff (rst) $rose(m_tvalid) |-> $past(cmd.finish))
    else $error("output valid without a finished request");

endmodule
`default_nettype wire

// ----- src/dabd_ctrl.sv -----
// Sequencer of the date walker: setup steps, the three walking passes and hand-off.
`default_nettype none
module dabd_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic          out_free,
  input  wire dabd_pkg::stat_t st,
  output dabd_pkg::cmd_t     cmd
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DIV   = 4'd1;
  localparam logic [3:0] S_REM   = 4'd2;
  localparam logic [3:0] S_ZEL   = 4'd3;
  localparam logic [3:0] S_MOD   = 4'd4;
  localparam logic [3:0] S_WDAY  = 4'd5;
  localparam logic [3:0] S_LEAD  = 4'd6;
  localparam logic [3:0] S_COUNT = 4'd7;
  localparam logic [3:0] S_TRAIL = 4'd8;
  localparam logic [3:0] S_DONE  = 4'd9;

  logic [3:0] state;
  logic [3:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    in_ready = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div = 1'b1;
        state_next = S_REM;
      end
      S_REM: begin
        cmd.rem = 1'b1;
        state_next = S_ZEL;
      end
      S_ZEL: begin
        cmd.zel = 1'b1;
        state_next = S_MOD;
      end
      S_MOD: begin
        if (st.bad) begin
          cmd.set_err = 1'b1;
          state_next = S_DONE;
        end else begin
          cmd.mod = 1'b1;
          state_next = S_WDAY;
        end
      end
      S_WDAY: begin
        cmd.wday = 1'b1;
        state_next = S_LEAD;
      end
      S_LEAD, S_TRAIL: begin
        if (st.weekend) begin
          if (st.at_end) begin
            cmd.set_err = 1'b1;
            state_next = S_DONE;
          end else begin
            cmd.step = 1'b1;
          end
        end else begin
          state_next = (state == S_LEAD) ? S_COUNT : S_DONE;
        end
      end
      S_COUNT: begin
        if (!st.rem_zero) begin
          if (st.at_end) begin
            cmd.set_err = 1'b1;
            state_next = S_DONE;
          end else begin
            cmd.step = 1'b1;
            cmd.dec = !st.weekend;
          end
        end else begin
          state_next = S_TRAIL;
        end
      end
      S_DONE: begin
        if (out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// ----- src/dabd_dp.sv -----
// Datapath of the date walker: start-date checks, weekday by Zeller, day stepping.
`default_nettype none
module dabd_dp (
  input  wire logic                             clk,
  input  wire dabd_pkg::cmd_t                   cmd,
  input  wire logic [dabd_pkg::YEAR_W-1:0]      in_year,
  input  wire logic [dabd_pkg::MONTH_W-1:0]     in_month,
  input  wire logic [dabd_pkg::DAY_W-1:0]       in_day,
  input  wire logic [dabd_pkg::VAC_W-1:0]       in_vac,
  output dabd_pkg::stat_t                       st,
  output dabd_pkg::res_t                        res
);

  // start date, kept for the error echo
  logic [dabd_pkg::YEAR_W-1:0] sy;
  logic [dabd_pkg::MONTH_W-1:0] sm;
  logic [dabd_pkg::DAY_W-1:0] sd;
  logic rng_bad;
  logic bad;
  logic err;

  // Zeller terms
  logic [6:0] cent;
  logic [6:0] yrem;
  logic [9:0] hsum;
  logic [6:0] q7;

  // walk state
  logic [dabd_pkg::YEAR_W-1:0] wy;
  logic [dabd_pkg::MONTH_W-1:0] wm;
  logic [dabd_pkg::DAY_W-1:0] wd;
  logic [dabd_pkg::WDAY_W-1:0] wk;
  logic [dabd_pkg::DAYS_WIDTH-1:0] rem;
  logic [1:0] ym4;
  logic [6:0] ym100;
  logic [1:0] cm4;

  logic [26:0] div_prod;
  logic [23:0] mod_prod;
  logic leap_start;
  logic leap_walk;
  logic [dabd_pkg::DAY_W-1:0] dim_walk;
  logic [dabd_pkg::MONTH_W-1:0] ma;
  logic [6:0] ka;
  logic [6:0] ja;
  logic [9:0] h_c;
  logic [9:0] r_full;
  logic [2:0] r7;

  always_comb begin
    div_prod = 27'(sy) * 27'(dabd_pkg::RECIP_100);
    mod_prod = 24'(hsum) * 24'(dabd_pkg::RECIP_7);
    leap_start = (yrem[1:0] == 2'd0 && yrem != 7'd0) || (yrem == 7'd0 && cent[1:0] == 2'd0);
    leap_walk = (ym4 == 2'd0 && ym100 != 7'd0) || (ym100 == 7'd0 && cm4 == 2'd0);
    dim_walk = dabd_pkg::days_in(wm, leap_walk);
    // January and February count as months 13 and 14 of the year before
    ma = sm;
    ka = yrem;
    ja = cent;
    if (sm <= 4'd2) begin
      ma = sm + 4'd12;
      if (yrem == 7'd0) begin
        ka = 7'd99;
        ja = cent - 7'd1;
      end else begin
        ka = yrem - 7'd1;
      end
    end
    h_c = 10'(sd) + 10'(dabd_pkg::zel_month(ma)) + 10'(ka) + 10'(ka >> 2)
        + 10'(ja >> 2) + 10'(ja) * 10'd5;
    r_full = hsum - 10'(q7) * 10'd7;
    r7 = r_full[2:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sy <= in_year;
      sm <= in_month;
      sd <= in_day;
      rem <= dabd_pkg::DAYS_WIDTH'(in_vac);
      rng_bad <= in_year < dabd_pkg::YEAR_MIN || in_year > dabd_pkg::YEAR_MAX
              || in_month == 4'd0 || in_month > dabd_pkg::MONTH_DEC || in_day == 5'd0;
    end
    if (cmd.div) begin
      cent <= div_prod[25:19];
    end
    if (cmd.rem) begin
      yrem <= 7'(sy - 14'(cent) * 14'd100);
    end
    if (cmd.zel) begin
      bad <= rng_bad || sd > dabd_pkg::days_in(sm, leap_start);
      hsum <= h_c;
      wy <= sy;
      wm <= sm;
      wd <= sd;
      ym4 <= yrem[1:0];
      ym100 <= yrem;
      cm4 <= cent[1:0];
    end
    if (cmd.mod) begin
      q7 <= mod_prod[22:16];
    end
    if (cmd.wday) begin
      wk <= (r7 >= 3'd2) ? r7 - 3'd2 : r7 + 3'd5;
    end
    if (cmd.step) begin
      if (wd >= dim_walk) begin
        if (wm >= dabd_pkg::MONTH_DEC) begin
          wy <= wy + 14'd1;
          wm <= 4'd1;
          ym4 <= ym4 + 2'd1;
          if (ym100 == 7'd99) begin
            ym100 <= 7'd0;
            cm4 <= cm4 + 2'd1;
          end else begin
            ym100 <= ym100 + 7'd1;
          end
        end else begin
          wm <= wm + 4'd1;
        end
        wd <= 5'd1;
      end else begin
        wd <= wd + 5'd1;
      end
      wk <= (wk == dabd_pkg::SUNDAY) ? 3'd0 : wk + 3'd1;
    end
    if (cmd.dec) begin
      rem <= rem - dabd_pkg::DAYS_WIDTH'(1);
    end
    if (cmd.load) begin
      err <= 1'b0;
    end else if (cmd.set_err) begin
      err <= 1'b1;
    end
  end

  always_comb begin
    st.bad = bad;
    st.weekend = wk >= dabd_pkg::SATURDAY;
    st.rem_zero = rem == '0;
    st.at_end = wd >= dim_walk && wm >= dabd_pkg::MONTH_DEC && wy >= dabd_pkg::YEAR_MAX;
    res.err = err;
    res.year = err ? sy : wy;
    res.month = err ? sm : wm;
    res.day = err ? sd : wd;
  end

endmodule
`default_nettype wire

// ----- bench/date_after_business_days_tb.sv -----
// Self-checking testbench of the business-day date walker.
`timescale 1ns / 100ps
module date_after_business_days_tb;

  // Request word as it travels on s_tdata: last field in the lowest bits.
  typedef struct packed {
    logic [dabd_pkg::VAC_W-1:0]   vac_days;
    logic [dabd_pkg::DAY_W-1:0]   day;
    logic [dabd_pkg::MONTH_W-1:0] month;
    logic [dabd_pkg::YEAR_W-1:0]  year;
  } request_t;

  localparam int MAX_GAP      = 16;
  localparam int SETTLE_TICKS = 20;
  localparam int SHOW_LIMIT   = 10;

  logic                             clk = 1'b0;
  logic                             rst = 1'b1;
  logic                             s_tvalid = 1'b0;
  logic                             s_tready;
  logic [dabd_pkg::IN_TDATA_W-1:0]  s_tdata = '0;
  logic                             m_tvalid;
  logic                             m_tready = 1'b0;
  logic [dabd_pkg::OUT_TDATA_W-1:0] m_tdata;
  logic                             m_tuser;

  // Return dates still owed by the block, oldest first.
  dabd_pkg::res_t return_queue[$];
  int unsigned    mismatch_count = 0;
  // When set, both sides run without gaps or stalls.
  bit             steady_flow = 1'b0;

  // Private copy of the walker state.
  logic [dabd_pkg::YEAR_W-1:0]     walk_year;
  logic [dabd_pkg::MONTH_W-1:0]    walk_month;
  logic [dabd_pkg::DAY_W-1:0]      walk_day;
  logic [dabd_pkg::WDAY_W-1:0]     walk_wday;
  logic [dabd_pkg::DAYS_WIDTH-1:0] days_left;

  date_after_business_days u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always #10 clk = ~clk;

  // ---------------------------------------------------------------------
  // Calendar prediction
  // ---------------------------------------------------------------------

  function automatic logic [dabd_pkg::DAY_W-1:0] month_length(
      input logic [dabd_pkg::MONTH_W-1:0] mon, input logic [dabd_pkg::YEAR_W-1:0] yr);
    bit leap_year;
    leap_year = ((yr % 4 == 0) && (yr % 100 != 0)) || (yr % 400 == 0);
    case (mon)
      4'd2: begin
        return leap_year ? 5'd29 : 5'd28;
      end
      4'd4, 4'd6, 4'd9, 4'd11: begin
        return 5'd30;
      end
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: begin
        return 5'd31;
      end
      default: begin
        return 5'd0;
      end
    endcase
  endfunction

  // Zeller's congruence, rotated so that Monday is 0 and Sunday is 6.
  function automatic logic [dabd_pkg::WDAY_W-1:0] weekday_of_date(input int yr, input int mon,
                                                                  input int dy);
    int cent;
    int yoc;
    int h;
    if (mon <= 2) begin
      mon += 12;
      yr -= 1;
    end
    yoc  = yr % 100;
    cent = yr / 100;
    h = (dy + (13 * (mon + 1)) / 5 + yoc + yoc / 4 + cent / 4 + 5 * cent) % 7;
    return dabd_pkg::WDAY_W'((h + 5) % 7);
  endfunction

  // Advance the walk one calendar day; false when it would pass 9999-12-31.
  function automatic bit advance_walk();
    if (walk_day >= month_length(walk_month, walk_year)) begin
      if (walk_month >= dabd_pkg::MONTH_DEC) begin
        if (walk_year >= dabd_pkg::YEAR_MAX) return 1'b0;
        walk_year  = walk_year + 14'd1;
        walk_month = 4'd1;
      end else begin
        walk_month = walk_month + 4'd1;
      end
      walk_day = 5'd1;
    end else begin
      walk_day = walk_day + 5'd1;
    end
    walk_wday = (walk_wday == dabd_pkg::SUNDAY) ? 3'd0 : walk_wday + 3'd1;
    return 1'b1;
  endfunction

  function automatic dabd_pkg::res_t predict_return(input request_t req);
    dabd_pkg::res_t ret;
    bit             failed;
    failed = (req.year < dabd_pkg::YEAR_MIN) || (req.year > dabd_pkg::YEAR_MAX) ||
             (req.month < 4'd1) || (req.month > dabd_pkg::MONTH_DEC) ||
             (req.day < 5'd1) || (req.day > month_length(req.month, req.year));
    if (!failed) begin
      walk_year  = req.year;
      walk_month = req.month;
      walk_day   = req.day;
      walk_wday  = weekday_of_date(int'(req.year), int'(req.month), int'(req.day));
      days_left  = dabd_pkg::DAYS_WIDTH'(req.vac_days);
      // lead skip: leave any weekend the vacation starts on
      while (!failed && walk_wday >= dabd_pkg::SATURDAY) failed = !advance_walk();
      // count down: only weekdays use up vacation
      while (!failed && days_left != 0) begin
        if (walk_wday < dabd_pkg::SATURDAY) days_left = days_left - dabd_pkg::DAYS_WIDTH'(1);
        failed = !advance_walk();
      end
      // trail skip: come back on a business day
      while (!failed && walk_wday >= dabd_pkg::SATURDAY) failed = !advance_walk();
    end
    if (failed) begin
      ret.year  = req.year;
      ret.month = req.month;
      ret.day   = req.day;
      ret.err   = 1'b1;
    end else begin
      ret.year  = walk_year;
      ret.month = walk_month;
      ret.day   = walk_day;
      ret.err   = 1'b0;
    end
    return ret;
  endfunction

  // ---------------------------------------------------------------------
  // Stream drivers
  // ---------------------------------------------------------------------

  // Offer one request word and hold it until taken; valid stays high on
  // return so that a following word can go out back to back.
  task automatic send_request(input logic [dabd_pkg::YEAR_W-1:0] yr,
                              input logic [dabd_pkg::MONTH_W-1:0] mon,
                              input logic [dabd_pkg::DAY_W-1:0] dy,
                              input logic [dabd_pkg::VAC_W-1:0] vac);
    request_t    req;
    int unsigned gap;
    req.year     = yr;
    req.month    = mon;
    req.day      = dy;
    req.vac_days = vac;
    gap = steady_flow ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {1'b0, req};
    do @(posedge clk); while (!s_tready);
    return_queue.push_back(predict_return(req));
  endtask

  // Drop valid and hold off until every owed return date has come back.
  task automatic wait_for_returns();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (return_queue.size() != 0);
  endtask

  // Random valid start date within the given years.
  task automatic pick_date(input int lo_year, input int hi_year,
                           output logic [dabd_pkg::YEAR_W-1:0] yr,
                           output logic [dabd_pkg::MONTH_W-1:0] mon,
                           output logic [dabd_pkg::DAY_W-1:0] dy);
    yr  = dabd_pkg::YEAR_W'($urandom_range(lo_year, hi_year));
    mon = dabd_pkg::MONTH_W'($urandom_range(1, 12));
    dy  = dabd_pkg::DAY_W'($urandom_range(1, int'(month_length(mon, yr))));
  endtask

  // Result side: draw a stall before each word, then hold ready until taken.
  initial begin : result_sink
    int unsigned stall;
    forever begin
      stall = steady_flow ? 0 : $urandom_range(0, MAX_GAP);
      repeat (stall) begin
        m_tready <= 1'b0;
        @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!(m_tvalid && m_tready));
    end
  end

  // Compare each returned word with the oldest owed return date.
  always @(posedge clk) begin : check_returns
    dabd_pkg::res_t               want;
    logic [dabd_pkg::YEAR_W-1:0]  got_year;
    logic [dabd_pkg::MONTH_W-1:0] got_month;
    logic [dabd_pkg::DAY_W-1:0]   got_day;
    got_year  = m_tdata[13:0];
    got_month = m_tdata[17:14];
    got_day   = m_tdata[22:18];
    if (!rst && m_tvalid && m_tready) begin
      if (return_queue.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= SHOW_LIMIT)
          $display("[%0t] unexpected return word %0d-%0d-%0d err=%0b", $realtime,
                   got_year, got_month, got_day, m_tuser);
      end else begin
        want = return_queue.pop_front();
        if (got_year !== want.year || got_month !== want.month ||
            got_day !== want.day || m_tuser !== want.err) begin
          mismatch_count++;
          if (mismatch_count <= SHOW_LIMIT)
            $display("[%0t] return date: expected %0d-%0d-%0d err=%0b, got %0d-%0d-%0d err=%0b",
                     $realtime, want.year, want.month, want.day, want.err,
                     got_year, got_month, got_day, m_tuser);
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Ordinary walks: weekend starts, zero days, month, year and leap rollover.
  task automatic test_calendar_walk();
    send_request(14'd2024, 4'd1, 5'd15, 16'd0);     // Monday, nothing off: same day
    send_request(14'd2024, 4'd1, 5'd13, 16'd0);     // Saturday, nothing off: Monday
    send_request(14'd2024, 4'd1, 5'd12, 16'd1);     // Friday off: skip the weekend after
    send_request(14'd2024, 4'd2, 5'd29, 16'd5);     // leap day
    send_request(14'd2000, 4'd2, 5'd29, 16'd3);     // leap century
    send_request(14'd2021, 4'd12, 5'd31, 16'd3);    // across the new year
    send_request(14'd2021, 4'd1, 5'd31, 16'd1);     // across a month end
  endtask

  // Start dates that must be echoed with the error flag.
  task automatic test_bad_start_dates();
    send_request(14'd2023, 4'd2, 5'd29, 16'd4);     // not a leap year
    send_request(14'd1900, 4'd2, 5'd29, 16'd4);     // century that is not leap
    send_request(14'd1582, 4'd12, 5'd31, 16'd2);    // before the first year
    send_request(14'd10000, 4'd1, 5'd1, 16'd2);     // beyond the last year
    send_request(14'h3fff, 4'hf, 5'h1f, 16'hffff);  // every bit set
    send_request(14'd0, 4'd0, 5'd0, 16'd0);         // every bit clear
    send_request(14'd2021, 4'd4, 5'd31, 16'd1);     // day past the month length
    send_request(14'd2021, 4'd13, 5'd1, 16'd1);     // month past December
    send_request(14'd2021, 4'd6, 5'd0, 16'd1);      // day zero
  endtask

  // Walks that reach or would pass the last representable day.
  task automatic test_year_end_limit();
    send_request(14'd9999, 4'd12, 5'd31, 16'd0);    // last day, nothing off
    send_request(14'd9999, 4'd12, 5'd31, 16'd1);    // one step too far
    send_request(14'd9999, 4'd12, 5'd20, 16'd20);   // runs out mid count
    send_request(14'd9999, 4'd12, 5'd24, 16'd4);    // lands on the day before the end
  endtask

  // Very long vacations, up to the largest count the field allows.
  task automatic test_long_vacations();
    send_request(14'd1583, 4'd1, 5'd1, 16'hffff);
    send_request(14'd5000, 4'd6, 5'd15, 16'd40000);
  endtask

  task automatic test_random_requests(input int unsigned count);
    logic [dabd_pkg::YEAR_W-1:0]  yr;
    logic [dabd_pkg::MONTH_W-1:0] mon;
    logic [dabd_pkg::DAY_W-1:0]   dy;
    logic [dabd_pkg::VAC_W-1:0]   vac;
    int unsigned                  pick;
    int unsigned                  long_count;
    long_count = 0;
    for (int unsigned i = 0; i < count; i++) begin
      // change the idling pattern every few dozen words
      if (i % 40 == 0) steady_flow = ($urandom_range(0, 3) == 0);
      // hold off once until the block has drained completely
      if (i == count / 2) wait_for_returns();
      pick = $urandom_range(0, 99);
      if (pick < 2 && long_count < 3) begin
        long_count++;
        pick_date(int'(dabd_pkg::YEAR_MIN), 9000, yr, mon, dy);
        vac = dabd_pkg::VAC_W'($urandom);
      end else if (pick < 62) begin
        pick_date(int'(dabd_pkg::YEAR_MIN), int'(dabd_pkg::YEAR_MAX), yr, mon, dy);
        vac = dabd_pkg::VAC_W'($urandom_range(0, 40));
      end else if (pick < 74) begin
        pick_date(int'(dabd_pkg::YEAR_MIN), int'(dabd_pkg::YEAR_MAX), yr, mon, dy);
        vac = dabd_pkg::VAC_W'($urandom_range(0, 400));
      end else if (pick < 80) begin
        pick_date(9975, int'(dabd_pkg::YEAR_MAX), yr, mon, dy);
        vac = dabd_pkg::VAC_W'($urandom_range(0, 2000));
      end else if (pick < 90) begin
        // valid month, day beyond its length (or zero for 31-day months)
        pick_date(int'(dabd_pkg::YEAR_MIN), int'(dabd_pkg::YEAR_MAX), yr, mon, dy);
        dy  = (month_length(mon, yr) == 5'd31) ? 5'd0 :
              dabd_pkg::DAY_W'($urandom_range(int'(month_length(mon, yr)) + 1, 31));
        vac = dabd_pkg::VAC_W'($urandom_range(0, 40));
      end else begin
        // raw noise over every bit of the date fields
        yr  = dabd_pkg::YEAR_W'($urandom);
        mon = dabd_pkg::MONTH_W'($urandom);
        dy  = dabd_pkg::DAY_W'($urandom);
        vac = dabd_pkg::VAC_W'($urandom_range(0, 40));
      end
      send_request(yr, mon, dy, vac);
    end
    steady_flow = 1'b0;
  endtask

  initial begin : stimulus
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_calendar_walk();
    test_bad_start_dates();
    test_year_end_limit();
    test_long_vacations();
    test_random_requests(400);
    wait_for_returns();
    repeat (SETTLE_TICKS) @(posedge clk);
    if (mismatch_count == 0 && return_queue.size() == 0) begin
      $display("** date_after_business_days: PASSED **");
    end else begin
      $display("** date_after_business_days: FAILED **");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin : run_limit
    #60ms;
    $display("** date_after_business_days: FAILED **");
    $finish;
  end

endmodule
